[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the link adaptation controller.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[rtl/rla_pkg.sv]
// Shared constants, codes and command word tables of the link adaptation controller.
// No dependencies; used by the channel interfaces and the top level.
package rla_pkg;

  // Command buffer limits
  localparam int CMD_MAX_LEN = 20;
  localparam int CMD_POS_W   = $clog2(CMD_MAX_LEN + 1);
  localparam int COUNT_W     = 32;
  localparam int WORD_COUNT  = 8;
  localparam int WORD_CHARS  = 6;

  // Event kinds
  localparam logic [2:0] KIND_RSSI       = 3'd0;
  localparam logic [2:0] KIND_CONNECT    = 3'd1;
  localparam logic [2:0] KIND_DISCONNECT = 3'd2;
  localparam logic [2:0] KIND_CMD        = 3'd3;
  localparam logic [2:0] KIND_PHY_DONE   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_STRONG   = 2'd0;
  localparam logic [1:0] REG_MODERATE = 2'd1;
  localparam logic [1:0] REG_WEAK     = 2'd2;
  localparam logic [1:0] REG_SHIFT    = 2'd3;

  // Power levels
  localparam logic [1:0] PWR_LOW    = 2'd0;
  localparam logic [1:0] PWR_MEDIUM = 2'd1;
  localparam logic [1:0] PWR_HIGH   = 2'd2;
  localparam logic [1:0] PWR_MAX    = 2'd3;

  // Transmit PHY codes
  localparam logic [1:0] PHY_1M = 2'd0;

  // Command status codes
  localparam logic [1:0] STATUS_NONE    = 2'd0;
  localparam logic [1:0] STATUS_OK      = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  // Reset values of the registers and the filter
  localparam logic signed [7:0] STRONG_RESET   = -8'sd67;
  localparam logic signed [7:0] MODERATE_RESET = -8'sd82;
  localparam logic signed [7:0] WEAK_RESET     = -8'sd92;
  localparam logic [2:0]        SHIFT_RESET    = 3'd3;
  localparam logic signed [7:0] FILTER_RESET   = -8'sd127;

  typedef enum logic [1:0] {
    ACT_AUTO,
    ACT_PHY,
    ACT_POWER
  } act_e;

  // Command words: length, text, action and its arguments
  localparam logic [2:0] WORD_LEN [WORD_COUNT] = '{
    3'd4, 3'd2, 3'd2, 3'd2, 3'd3, 3'd6, 3'd4, 3'd3
  };

  localparam logic [7:0] WORD_TEXT [WORD_COUNT][WORD_CHARS] = '{
    '{"A", "U", "T", "O", 8'h00, 8'h00},
    '{"1", "M", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "2", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "8", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"L", "O", "W", 8'h00, 8'h00, 8'h00},
    '{"M", "E", "D", "I", "U", "M"},
    '{"H", "I", "G", "H", 8'h00, 8'h00},
    '{"M", "A", "X", 8'h00, 8'h00, 8'h00}
  };

  localparam act_e WORD_ACT [WORD_COUNT] = '{
    ACT_AUTO, ACT_PHY, ACT_PHY, ACT_PHY, ACT_POWER, ACT_POWER, ACT_POWER, ACT_POWER
  };

  // For PHY words: coded flag; for power words: the level
  localparam logic [1:0] WORD_ARG_A [WORD_COUNT] = '{
    2'd0, 2'd0, 2'd1, 2'd1, PWR_LOW, PWR_MEDIUM, PWR_HIGH, PWR_MAX
  };

  // For PHY words: S8 flag
  localparam logic WORD_ARG_B [WORD_COUNT] = '{
    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0
  };

endpackage

[rtl/rla_if.sv]
// Request and result channel interfaces of the link adaptation controller.
// Depends on rla_pkg for the counter width.

interface rla_req_if;
  import rla_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic signed [7:0] rssi;
  logic [7:0]        cmd_byte;
  logic              cmd_last;
  logic [1:0]        new_phy;

  modport source (output valid, kind, rssi, cmd_byte, cmd_last, new_phy, input ready);
  modport sink (input valid, kind, rssi, cmd_byte, cmd_last, new_phy, output ready);
endinterface

interface rla_res_if;
  import rla_pkg::*;
  logic               valid;
  logic               ready;
  logic               power_request;
  logic [1:0]         power_level;
  logic               phy_request;
  logic               phy_coded;
  logic               coding_s8;
  logic signed [7:0]  filtered_rssi;
  logic [COUNT_W-1:0] sample_count;
  logic [1:0]         current_phy;
  logic [1:0]         current_power;
  logic [1:0]         command_status;

  modport source (output valid, power_request, power_level, phy_request, phy_coded,
                  coding_s8, filtered_rssi, sample_count, current_phy, current_power,
                  command_status, input ready);
  modport sink (input valid, power_request, power_level, phy_request, phy_coded,
                coding_s8, filtered_rssi, sample_count, current_phy, current_power,
                command_status, output ready);
endinterface

[rtl/rssi_link_adaptation_controller.sv]
// Top level of the RSSI link adaptation controller: filter, region policy and
// command parser. Depends on rla_pkg, rla_if.sv and assert_macros.svh.
//
// Takes one request per clock cycle while the input register is not stalled.
// A request is captured in an input register, handled by one step of shallow
// logic (filter update, threshold compare, command word match) and lands in
// the result register once that register is free or its result is taken.
// State written by one request is seen by the very next one. Command bytes
// without the last flag and unused kinds give no result. The input register
// stalls only while the result register holds an untaken result.
`include "assert_macros.svh"

module rssi_link_adaptation_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [7:0]            cfg_wdata_i,
  rla_req_if.sink               req_i,
  rla_res_if.source             res_o
);
  import rla_pkg::*;

  typedef struct packed {
    logic [1:0] power;
    logic       coded;
    logic       s8;
  } policy_t;

  typedef struct packed {
    logic               power_request;
    logic [1:0]         power_level;
    logic               phy_request;
    logic               phy_coded;
    logic               coding_s8;
    logic signed [7:0]  filtered_rssi;
    logic [COUNT_W-1:0] sample_count;
    logic [1:0]         current_phy;
    logic [1:0]         current_power;
    logic [1:0]         command_status;
  } res_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic signed [7:0] rssi;
    logic [7:0]        cmd_byte;
    logic              cmd_last;
    logic [1:0]        new_phy;
  } req_t;

  // Region policy: tested strong, moderate, weak in that order
  function automatic policy_t link_policy(logic signed [7:0] lvl,
                                          logic signed [7:0] strong_lvl,
                                          logic signed [7:0] moderate_lvl,
                                          logic signed [7:0] weak_lvl);
    policy_t p;
    if (lvl >= strong_lvl) begin
      p = '{power: PWR_LOW, coded: 1'b0, s8: 1'b0};
    end else if (lvl >= moderate_lvl) begin
      p = '{power: PWR_MEDIUM, coded: 1'b0, s8: 1'b0};
    end else if (lvl >= weak_lvl) begin
      p = '{power: PWR_HIGH, coded: 1'b1, s8: 1'b0};
    end else begin
      p = '{power: PWR_MAX, coded: 1'b1, s8: 1'b1};
    end
    return p;
  endfunction

  // Configuration registers
  logic signed [7:0] strong_q, moderate_q, weak_q;
  logic [2:0]        shift_q;

  // Link state
  logic                 conn_q, conn_d;
  logic signed [7:0]    filt_q, filt_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [1:0]           phy_q, phy_d;
  logic [1:0]           power_q, power_d;
  logic [CMD_POS_W-1:0] pos_q, pos_d;
  logic                 term_q, term_d;
  logic [WORD_COUNT-1:0] cand_q, cand_d;

  // Pipeline registers
  logic in_valid_q;
  req_t in_q;
  logic res_valid_q, res_valid_d;
  res_t res_q, res_d;

  logic    advance, fire, has_result;
  policy_t pol_new, pol_cur, pol_sel;
  logic    use_pol;
  logic signed [16:0] scaled, sum, bias, quot;
  logic signed [7:0]  filt_new;
  logic [7:0]         up_byte;
  logic               found;
  logic [2:0]         sel;
  logic               do_power, do_phy;
  logic [1:0]         req_power;
  logic               req_coded, req_s8;

  // Handshake: the input register moves on whenever the result register frees up
  assign advance     = !res_valid_q || res_o.ready;
  assign fire        = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strong_q   <= STRONG_RESET;
      moderate_q <= MODERATE_RESET;
      weak_q     <= WEAK_RESET;
      shift_q    <= SHIFT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STRONG:   strong_q   <= cfg_wdata_i;
        REG_MODERATE: moderate_q <= cfg_wdata_i;
        REG_WEAK:     weak_q     <= cfg_wdata_i;
        REG_SHIFT:    shift_q    <= cfg_wdata_i[2:0];
        default:      shift_q    <= shift_q;
      endcase
    end
  end

  // Filter update: (raw + (2^shift - 1) * filtered) / 2^shift toward zero
  always_comb begin
    scaled   = 17'(filt_q) <<< shift_q;
    sum      = scaled - 17'(filt_q) + 17'(in_q.rssi);
    bias     = sum[16] ? ((17'sd1 <<< shift_q) - 17'sd1) : 17'sd0;
    quot     = (sum + bias) >>> shift_q;
    // Seed the filter on the first sample after reset, connect or wrap
    filt_new = (count_q == '0) ? in_q.rssi : quot[7:0];
  end

  // Uppercase the command byte
  assign up_byte = (in_q.cmd_byte >= "a" && in_q.cmd_byte <= "z") ?
                   in_q.cmd_byte - 8'h20 : in_q.cmd_byte;

  // Policy on the new filter value and on the stored one
  assign pol_new = link_policy(filt_new, strong_q, moderate_q, weak_q);
  assign pol_cur = link_policy(filt_q, strong_q, moderate_q, weak_q);

  // Step: next state and result of the held request
  always_comb begin
    conn_d     = conn_q;
    filt_d     = filt_q;
    count_d    = count_q;
    phy_d      = phy_q;
    pos_d      = pos_q;
    term_d     = term_q;
    cand_d     = cand_q;
    has_result = 1'b0;
    use_pol    = 1'b0;
    pol_sel    = pol_cur;
    do_power   = 1'b0;
    do_phy     = 1'b0;
    req_power  = PWR_LOW;
    req_coded  = 1'b0;
    req_s8     = 1'b0;
    found      = 1'b0;
    sel        = '0;
    res_d      = '0;
    res_d.command_status = STATUS_NONE;

    unique case (in_q.kind)
      KIND_RSSI: begin
        has_result = 1'b1;
        filt_d     = filt_new;
        count_d    = count_q + COUNT_W'(1);
        use_pol    = 1'b1;
        pol_sel    = pol_new;
      end
      KIND_CONNECT: begin
        has_result = 1'b1;
        conn_d     = 1'b1;
        filt_d     = FILTER_RESET;
        count_d    = '0;
        do_power   = 1'b1;
        req_power  = PWR_MAX;
        do_phy     = 1'b1;
        req_coded  = 1'b1;
        req_s8     = 1'b1;
      end
      KIND_DISCONNECT: begin
        has_result = 1'b1;
        conn_d     = 1'b0;
        phy_d      = PHY_1M;
      end
      KIND_CMD: begin
        // Absorb the byte unless the text has ended or is full
        if (!term_q && pos_q < CMD_POS_W'(CMD_MAX_LEN)) begin
          if (in_q.cmd_byte == 8'h00) begin
            term_d = 1'b1;
          end else begin
            for (int i = 0; i < WORD_COUNT; i++) begin
              if (pos_q >= CMD_POS_W'(WORD_LEN[i]) ||
                  WORD_TEXT[i][pos_q[2:0]] != up_byte) begin
                cand_d[i] = 1'b0;
              end
            end
            pos_d = pos_q + CMD_POS_W'(1);
          end
        end
        if (in_q.cmd_last) begin
          has_result = 1'b1;
          // First surviving word whose length matches wins
          for (int i = 0; i < WORD_COUNT; i++) begin
            if (!found && cand_d[i] && pos_d == CMD_POS_W'(WORD_LEN[i])) begin
              found = 1'b1;
              sel   = 3'(i);
            end
          end
          res_d.command_status = found ? STATUS_OK : STATUS_UNKNOWN;
          if (found) begin
            unique case (WORD_ACT[sel])
              ACT_AUTO: use_pol = 1'b1;
              ACT_PHY: begin
                do_phy    = 1'b1;
                req_coded = WORD_ARG_A[sel][0];
                req_s8    = WORD_ARG_B[sel];
              end
              ACT_POWER: begin
                do_power  = 1'b1;
                req_power = WORD_ARG_A[sel];
              end
              default: use_pol = 1'b0;
            endcase
          end
          pos_d  = '0;
          term_d = 1'b0;
          cand_d = '1;
        end
      end
      KIND_PHY_DONE: begin
        has_result = 1'b1;
        phy_d      = in_q.new_phy;
      end
      default: has_result = 1'b0;
    endcase

    if (use_pol) begin
      do_power  = 1'b1;
      req_power = pol_sel.power;
      do_phy    = 1'b1;
      req_coded = pol_sel.coded;
      req_s8    = pol_sel.s8;
    end

    // Requests go out only while connected
    power_d = (do_power && conn_d) ? req_power : power_q;
    if (do_power && conn_d) begin
      res_d.power_request = 1'b1;
      res_d.power_level   = req_power;
    end
    if (do_phy && conn_d) begin
      res_d.phy_request = 1'b1;
      res_d.phy_coded   = req_coded;
      res_d.coding_s8   = req_s8;
    end
    res_d.filtered_rssi = filt_d;
    res_d.sample_count  = count_d;
    res_d.current_phy   = phy_d;
    res_d.current_power = power_d;
  end

  assign res_valid_d = (fire && has_result) ? 1'b1 : (res_o.ready ? 1'b0 : res_valid_q);

  // Hold state, input register and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q      <= 1'b0;
      filt_q      <= FILTER_RESET;
      count_q     <= '0;
      phy_q       <= PHY_1M;
      power_q     <= PWR_MEDIUM;
      pos_q       <= '0;
      term_q      <= 1'b0;
      cand_q      <= '1;
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        conn_q  <= conn_d;
        filt_q  <= filt_d;
        count_q <= count_d;
        phy_q   <= phy_d;
        power_q <= power_d;
        pos_q   <= pos_d;
        term_q  <= term_d;
        cand_q  <= cand_d;
      end
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers without reset
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= '{kind: req_i.kind, rssi: req_i.rssi, cmd_byte: req_i.cmd_byte,
                cmd_last: req_i.cmd_last, new_phy: req_i.new_phy};
    end
    if (fire && has_result) begin
      res_q <= res_d;
    end
  end

  // Drive the result channel
  assign res_o.valid          = res_valid_q;
  assign res_o.power_request  = res_q.power_request;
  assign res_o.power_level    = res_q.power_level;
  assign res_o.phy_request    = res_q.phy_request;
  assign res_o.phy_coded      = res_q.phy_coded;
  assign res_o.coding_s8      = res_q.coding_s8;
  assign res_o.filtered_rssi  = res_q.filtered_rssi;
  assign res_o.sample_count   = res_q.sample_count;
  assign res_o.current_phy    = res_q.current_phy;
  assign res_o.current_power  = res_q.current_power;
  assign res_o.command_status = res_q.command_status;

  // Checks
  `ASSERT_ALWAYS(a_power_req_connected,
    (res_valid_q && (res_q.power_request || res_q.phy_request)) |-> conn_q,
    "request issued while not connected")
  `ASSERT_ALWAYS(a_phy_fields_idle,
    (res_valid_q && !res_q.phy_request) |-> (!res_q.phy_coded && !res_q.coding_s8),
    "phy fields set without a phy request")
  `ASSERT_ALWAYS(a_power_tracks_state,
    res_valid_q |-> (res_q.current_power == power_q && res_q.sample_count == count_q),
    "pending result disagrees with stored state")
  `ASSERT_NEVER(a_pos_bound, pos_q > CMD_POS_W'(CMD_MAX_LEN),
    "command position past the maximum length")

endmodule

[sim/testbench.sv]
// Self-checking testbench of the RSSI link adaptation controller.
// Depends on rla_pkg, rla_if.sv and the controller top level from rtl/.
`timescale 1ns / 1ps

module testbench;
  import rla_pkg::*;

  localparam int         STUCK_LIMIT  = 3000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         PHASE_ITEMS  = 110;
  localparam int         PHASES       = 6;
  localparam int         DRAIN_CYCLES = 4;
  localparam int         SETTLE_END   = 10;
  localparam int         PRINT_LIMIT  = 40;
  localparam logic [2:0] KIND_IGNORED = 3'd5;

  // Command word indexes in the word table below
  localparam int WORD_AUTO  = 0;
  localparam int WORD_1M    = 1;
  localparam int WORD_S8    = 3;
  localparam int WORD_LOW   = 4;
  localparam int WORD_TOTAL = 8;

  // Idle modes of the phases
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SRC  = 1;
  localparam int IDLE_SINK = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct packed {
    logic [2:0]        kind;
    logic signed [7:0] rssi;
    logic [7:0]        cmd_byte;
    logic              cmd_last;
    logic [1:0]        new_phy;
  } req_t;

  typedef struct packed {
    logic               power_request;
    logic [1:0]         power_level;
    logic               phy_request;
    logic               phy_coded;
    logic               coding_s8;
    logic signed [7:0]  filtered_rssi;
    logic [COUNT_W-1:0] sample_count;
    logic [1:0]         current_phy;
    logic [1:0]         current_power;
    logic [1:0]         command_status;
  } res_t;

  typedef logic [7:0] byte_q [$];

  // Link policy predictor plus queue of expected results
  class link_scoreboard;
    string              words [WORD_TOTAL];
    logic signed [7:0]  strong_thr;
    logic signed [7:0]  moderate_thr;
    logic signed [7:0]  weak_thr;
    logic [2:0]         shift;
    bit                 linked;
    logic signed [7:0]  level;
    logic [COUNT_W-1:0] samples;
    logic [1:0]         phy_now;
    logic [1:0]         power_now;
    int                 cmd_pos;
    bit                 cmd_done;
    logic [7:0]         cand;
    res_t               draft;
    res_t               awaited [$];
    int                 errors;
    int                 requests;
    int                 results;
    int                 recognized;

    function new();
      words = '{"AUTO", "1M", "S2", "S8", "LOW", "MEDIUM", "HIGH", "MAX"};
      strong_thr   = -8'sd67;
      moderate_thr = -8'sd82;
      weak_thr     = -8'sd92;
      shift        = 3'd3;
      linked       = 1'b0;
      level        = -8'sd127;
      samples      = '0;
      phy_now      = PHY_1M;
      power_now    = PWR_MEDIUM;
      clear_command();
    endfunction

    function void clear_command();
      cmd_pos  = 0;
      cmd_done = 1'b0;
      cand     = '1;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] value);
      case (idx)
        REG_STRONG:   strong_thr   = value;
        REG_MODERATE: moderate_thr = value;
        REG_WEAK:     weak_thr     = value;
        REG_SHIFT:    shift        = value[2:0];
        default: ;
      endcase
    endfunction

    function void give_power(logic [1:0] lvl);
      if (!linked) return;
      draft.power_request = 1'b1;
      draft.power_level   = lvl;
      power_now           = lvl;
    endfunction

    function void give_phy(bit coded, bit s8);
      if (!linked) return;
      draft.phy_request = 1'b1;
      draft.phy_coded   = coded;
      draft.coding_s8   = s8;
    endfunction

    // Pick the region in fixed order, whatever the thresholds
    function void region_policy();
      if (level >= strong_thr) begin
        give_power(PWR_LOW);
        give_phy(1'b0, 1'b0);
      end else if (level >= moderate_thr) begin
        give_power(PWR_MEDIUM);
        give_phy(1'b0, 1'b0);
      end else if (level >= weak_thr) begin
        give_power(PWR_HIGH);
        give_phy(1'b1, 1'b0);
      end else begin
        give_power(PWR_MAX);
        give_phy(1'b1, 1'b1);
      end
    endfunction

    function void filter_sample(logic signed [7:0] raw);
      int den;
      int sum;
      if (samples == '0) begin
        level = raw;
      end else begin
        den   = 1 << shift;
        sum   = int'(raw) + (den - 1) * int'(level);
        level = 8'(sum / den);
      end
      samples = samples + 1'b1;
      region_policy();
    endfunction

    // Narrow the candidate words by one uppercased byte
    function void feed_byte(logic [7:0] b);
      if (cmd_done || cmd_pos >= CMD_MAX_LEN) return;
      if (b == 8'h00) begin
        cmd_done = 1'b1;
        return;
      end
      if (b >= "a" && b <= "z") b = b - 8'd32;
      for (int i = 0; i < WORD_TOTAL; i++) begin
        if (cmd_pos >= words[i].len() || 8'(words[i][cmd_pos]) != b) cand[i] = 1'b0;
      end
      cmd_pos++;
    endfunction

    function void finish_command();
      draft.command_status = STATUS_UNKNOWN;
      for (int i = 0; i < WORD_TOTAL; i++) begin
        if (cand[i] && words[i].len() == cmd_pos) begin
          draft.command_status = STATUS_OK;
          recognized++;
          if (i == WORD_AUTO) region_policy();
          else if (i < WORD_LOW) give_phy(i != WORD_1M, i == WORD_S8);
          else give_power(2'(i - WORD_LOW));
          break;
        end
      end
      clear_command();
    endfunction

    function void note_request(req_t r);
      bit answers;
      answers = 1'b1;
      draft   = '0;
      requests++;
      case (r.kind)
        KIND_RSSI: filter_sample(r.rssi);
        KIND_CONNECT: begin
          linked  = 1'b1;
          level   = -8'sd127;
          samples = '0;
          give_power(PWR_MAX);
          give_phy(1'b1, 1'b1);
        end
        KIND_DISCONNECT: begin
          linked  = 1'b0;
          phy_now = PHY_1M;
        end
        KIND_CMD: begin
          answers = r.cmd_last;
          feed_byte(r.cmd_byte);
          if (r.cmd_last) finish_command();
        end
        KIND_PHY_DONE: phy_now = r.new_phy;
        default: answers = 1'b0;
      endcase
      if (answers) begin
        draft.filtered_rssi = level;
        draft.sample_count  = samples;
        draft.current_phy   = phy_now;
        draft.current_power = power_now;
        awaited.push_back(draft);
      end
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task check_result(res_t got);
      res_t want;
      results++;
      if (awaited.size() == 0) begin
        report("result with nothing awaited, sample_count", got.sample_count, 0);
        return;
      end
      want = awaited.pop_front();
      if (got.power_request !== want.power_request)
        report("power_request", got.power_request, want.power_request);
      if (got.power_level !== want.power_level)
        report("power_level", got.power_level, want.power_level);
      if (got.phy_request !== want.phy_request)
        report("phy_request", got.phy_request, want.phy_request);
      if (got.phy_coded !== want.phy_coded)
        report("phy_coded", got.phy_coded, want.phy_coded);
      if (got.coding_s8 !== want.coding_s8)
        report("coding_s8", got.coding_s8, want.coding_s8);
      if (got.filtered_rssi !== want.filtered_rssi)
        report("filtered_rssi", got.filtered_rssi, want.filtered_rssi);
      if (got.sample_count !== want.sample_count)
        report("sample_count", got.sample_count, want.sample_count);
      if (got.current_phy !== want.current_phy)
        report("current_phy", got.current_phy, want.current_phy);
      if (got.current_power !== want.current_power)
        report("current_power", got.current_power, want.current_power);
      if (got.command_status !== want.command_status)
        report("command_status", got.command_status, want.command_status);
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_wdata;
  logic       sink_ready = 1'b0;
  int         src_idle_pct;
  int         sink_stall_pct = 0;
  bit         hold_req = 1'b0;
  bit         hold_seen = 1'b0;
  int         hold_left = 0;
  int         stuck = 0;
  int         settings = 0;

  link_scoreboard sb = new();

  rla_req_if req_ch ();
  rla_res_if res_ch ();

  assign res_ch.ready = sink_ready;

  rssi_link_adaptation_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .res_o       (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Observe both channels, drive the sink ready and guard against a hang
  always @(posedge clk) begin
    bit req_fire;
    bit res_fire;
    req_fire = rst_n && req_ch.valid && req_ch.ready;
    res_fire = rst_n && res_ch.valid && res_ch.ready;
    if (req_fire)
      sb.note_request('{req_ch.kind, req_ch.rssi, req_ch.cmd_byte, req_ch.cmd_last,
                        req_ch.new_phy});
    if (res_fire)
      sb.check_result('{res_ch.power_request, res_ch.power_level, res_ch.phy_request,
                        res_ch.phy_coded, res_ch.coding_s8, res_ch.filtered_rssi,
                        res_ch.sample_count, res_ch.current_phy, res_ch.current_power,
                        res_ch.command_status});
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      sink_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
    if (req_fire || res_fire) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // Offer one request after an optional idle gap and hold it until taken
  task automatic send_req(input req_t r);
    if ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= r.kind;
    req_ch.rssi     <= r.rssi;
    req_ch.cmd_byte <= r.cmd_byte;
    req_ch.cmd_last <= r.cmd_last;
    req_ch.new_phy  <= r.new_phy;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  // Fields that a kind does not use carry random bits
  function automatic req_t noisy_req(logic [2:0] kind);
    req_t r;
    r.kind     = kind;
    r.rssi     = $urandom;
    r.cmd_byte = $urandom;
    r.cmd_last = $urandom;
    r.new_phy  = $urandom;
    return r;
  endfunction

  task automatic send_kind(input logic [2:0] kind);
    send_req(noisy_req(kind));
  endtask

  task automatic send_rssi(input logic signed [7:0] v);
    req_t r;
    r      = noisy_req(KIND_RSSI);
    r.rssi = v;
    send_req(r);
  endtask

  task automatic send_command(input byte_q q);
    req_t r;
    foreach (q[i]) begin
      r          = noisy_req(KIND_CMD);
      r.cmd_byte = q[i];
      r.cmd_last = (i == q.size() - 1);
      send_req(r);
    end
  endtask

  function automatic byte_q text_bytes(string s, bit mix);
    byte_q q;
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix && c >= "A" && c <= "Z" && $urandom_range(1)) c = c + 8'd32;
      q.push_back(c);
    end
    return q;
  endfunction

  // Mostly real words in mixed case, the rest broken or junk commands
  function automatic byte_q random_command();
    byte_q q;
    string w;
    int style;
    int n;
    style = $urandom_range(9);
    w     = sb.words[$urandom_range(WORD_TOTAL - 1)];
    if (style <= 4) begin
      q = text_bytes(w, 1'b1);
    end else if (style == 5) begin
      q = text_bytes(w, 1'b1);
      q.push_back(8'h00);
      repeat ($urandom_range(3)) q.push_back(8'($urandom));
    end else if (style == 6) begin
      q = text_bytes(w, 1'b1);
      q.push_back(8'("A" + $urandom_range(25)));
    end else if (style == 7) begin
      q = text_bytes(w.substr(0, $urandom_range(w.len() - 2)), 1'b1);
    end else if (style == 8) begin
      n = 18 + $urandom_range(8);
      repeat (n) q.push_back(8'("A" + $urandom_range(25)));
    end else begin
      n = 1 + $urandom_range(3);
      repeat (n) q.push_back(8'($urandom));
    end
    return q;
  endfunction

  function automatic logic signed [7:0] pick_rssi();
    if ($urandom_range(9) < 7) return 8'($urandom_range(80) - 110);
    return 8'($urandom);
  endfunction

  task automatic run_random(input int target);
    int sent;
    int w;
    byte_q q;
    req_t r;
    sent = 0;
    while (sent < target) begin
      w = $urandom_range(99);
      if (w < 45) begin
        send_rssi(pick_rssi());
        sent++;
      end else if (w < 50) begin
        send_kind(KIND_CONNECT);
        sent++;
      end else if (w < 54) begin
        send_kind(KIND_DISCONNECT);
        sent++;
      end else if (w < 62) begin
        send_kind(KIND_PHY_DONE);
        sent++;
      end else if (w < 93) begin
        q = random_command();
        send_command(q);
        sent += q.size();
      end else begin
        r = noisy_req(KIND_IGNORED + 3'($urandom_range(2)));
        send_req(r);
      end
    end
  endtask

  // Drop valid and wait until every result is in and the pipe is empty
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic apply_settings(input logic [7:0] strong_lvl, input logic [7:0] moderate_lvl,
                                input logic [7:0] weak_lvl, input logic [2:0] shift);
    write_reg(REG_STRONG, strong_lvl);
    write_reg(REG_MODERATE, moderate_lvl);
    write_reg(REG_WEAK, weak_lvl);
    write_reg(REG_SHIFT, {5'd0, shift});
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic set_idle(input int mode);
    src_idle_pct    = (mode == IDLE_SRC) ? 45 : (mode == IDLE_BOTH) ? 27 : 0;
    sink_stall_pct <= (mode == IDLE_SINK) ? 45 : (mode == IDLE_BOTH) ? 27 : 0;
  endtask

  initial begin
    byte_q q;
    req_t r;
    rst_n           = 1'b0;
    src_idle_pct    = 0;
    cfg_we          <= 1'b0;
    cfg_idx         <= REG_STRONG;
    cfg_wdata       <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.kind     <= KIND_RSSI;
    req_ch.rssi     <= '0;
    req_ch.cmd_byte <= '0;
    req_ch.cmd_last <= 1'b0;
    req_ch.new_phy  <= PHY_1M;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: samples while unlinked, connect, commands of each action and an unknown one, relink
    send_rssi(8'sd127);
    send_rssi(-8'sd128);
    r         = noisy_req(KIND_PHY_DONE);
    r.new_phy = 2'd3;
    send_req(r);
    send_kind(KIND_CONNECT);
    send_rssi(-8'sd128);
    send_rssi(8'sd127);
    send_command(text_bytes("s8", 1'b0));
    q = text_bytes("Max", 1'b0);
    q.push_back(8'h00);
    q.push_back("Z");
    send_command(q);
    q = {8'hFF};
    send_command(q);
    send_command(text_bytes("auto", 1'b0));
    r = '1;
    send_req(r);
    send_kind(KIND_DISCONNECT);
    send_command(text_bytes("LOW", 1'b0));
    send_kind(KIND_CONNECT);
    send_kind(KIND_CONNECT);
    drain();

    // Random phases: each but the first writes thresholds and shift, and each sets an idle pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: apply_settings(8'sd127, -8'sd128, -8'sd128, 3'd7);
        2: apply_settings(-8'sd128, -8'sd128, -8'sd128, 3'd1);
        3: apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 3'd0);
        4: apply_settings(8'($urandom_range(70) - 110), 8'($urandom_range(70) - 110),
                          8'($urandom_range(70) - 110), 3'(1 + $urandom_range(6)));
        5: apply_settings(-8'sd67, -8'sd82, -8'sd92, 3'd3);
        default: ;
      endcase
      set_idle(ph % 4);
      if (ph == 2) hold_req <= ~hold_req;
      run_random(PHASE_ITEMS);
      drain();
    end

    repeat (SETTLE_END) @(posedge clk);
    $display("run: %0d requests, %0d results, %0d commands recognized, %0d register settings",
             sb.requests, sb.results, sb.recognized, settings);
    $display("run: idle and stall mixes on both channels, one long sink hold-off");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results still awaited", sb.errors, sb.awaited.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/rla_pkg.sv
rtl/rla_if.sv
rtl/rssi_link_adaptation_controller.sv
sim/testbench.sv
